/* hdl/chacha20_drbg_keystream_unit_macros.svh */
// assertion macros for the keystream unit
// used by the top level only
`ifndef CHACHA20_DRBG_KEYSTREAM_UNIT_MACROS_SVH
`define CHACHA20_DRBG_KEYSTREAM_UNIT_MACROS_SVH
// implication checked on every rising edge outside reset
`define CDK_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define CDK_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* hdl/cdk_pkg.sv */
// package for the chacha20 keystream unit: types, constants, round helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cdk_pkg;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;
    localparam logic [31:0] RESEED_RESET = 32'h0010_0000;
    localparam logic [33:0] SAT34 = 34'h3_FFFF_FFFF;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_block;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FEED,
        ST_OUT,
        ST_RAT_ROUND,
        ST_RAT_FEED
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic odd;
    } t_core_ctrl;

    function automatic t_word rotl(input t_word x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // one quarter round on four words
    function automatic logic [127:0] qr(input t_word a_i, input t_word b_i,
                                        input t_word c_i, input t_word d_i);
        t_word a, b, c, d;
        a = a_i; b = b_i; c = c_i; d = d_i;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        qr = {a, b, c, d};
    endfunction
endpackage
`default_nettype wire

/* hdl/cdk_round_core.sv */
// chacha20 round engine: one column or diagonal round per cycle while step is set
// depends on cdk_pkg
`timescale 1ns / 1ps
`default_nettype none
module cdk_round_core import cdk_pkg::*; (
    input  wire        i_clk,
    input  t_core_ctrl i_ctrl,
    input  t_block     i_init,
    output t_block     o_state
);
    t_block r_x;
    t_block n_x;

    // four quarter rounds on column or diagonal groups
    always_comb begin
        n_x = r_x;
        if (!i_ctrl.odd) begin
            for (int q = 0; q < 4; q++) begin
                {n_x[q], n_x[4+q], n_x[8+q], n_x[12+q]} =
                    qr(r_x[q], r_x[4+q], r_x[8+q], r_x[12+q]);
            end
        end else begin
            for (int q = 0; q < 4; q++) begin
                {n_x[q], n_x[4+((q+1)%4)], n_x[8+((q+2)%4)], n_x[12+((q+3)%4)]} =
                    qr(r_x[q], r_x[4+((q+1)%4)], r_x[8+((q+2)%4)], r_x[12+((q+3)%4)]);
            end
        end
    end

    // working state register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_init;
        end else if (i_ctrl.step) begin
            r_x <= n_x;
        end
    end

    assign o_state = r_x;
endmodule
`default_nettype wire

/* hdl/chacha20_drbg_keystream_unit.sv */
// chacha20 drbg keystream unit, top level: sequencer, drbg state, output
// depends on cdk_pkg, cdk_round_core and the assertion macro header
// sequence: a load state, the round states, a feed-forward state, then 16 words out
// a new request is taken only in idle, and output stalls hold the words; the last
// request of a call adds a key ratchet (rounds and feed-forward), all on one round core
// reset (synchronous, active low): key, nonce, counter and byte counts cleared, unseeded,
// reseed interval 1048576
`timescale 1ns / 1ps
`default_nettype none
`include "chacha20_drbg_keystream_unit_macros.svh"
module chacha20_drbg_keystream_unit import cdk_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [6:0]  i_byte_count,
    input  wire         i_last_of_call,
    input  wire  [63:0] i_entropy_key0,
    input  wire  [63:0] i_entropy_key1,
    input  wire  [63:0] i_entropy_key2,
    input  wire  [63:0] i_entropy_key3,
    input  wire  [63:0] i_entropy_nonce,
    input  wire  [63:0] i_entropy_extra,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_keystream_word,
    output logic [3:0]  o_word_index,
    output logic        o_last,
    output logic        o_reseeded
);
    localparam int NROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RW = $clog2(NROUNDS + 1);

    t_state r_state, n_state;
    logic [RW-1:0] r_rnd;
    logic [3:0]    r_idx;
    t_word  r_key [8];
    t_word  r_ctr;
    t_word  r_nonce [3];
    logic   r_seeded, r_inprog, r_lastcall, r_resd;
    logic [33:0] r_prod, r_call;
    logic [31:0] r_interval;
    t_block r_init, r_out;
    t_block n_init, core_x;
    t_core_ctrl ctrl;
    logic accept;

    assign accept = i_valid && o_ready;

    // block input from current drbg state
    always_comb begin
        n_init[0] = SIGMA0; n_init[1] = SIGMA1;
        n_init[2] = SIGMA2; n_init[3] = SIGMA3;
        for (int i = 0; i < 8; i++) n_init[4+i] = r_key[i];
        n_init[12] = r_ctr;
        for (int i = 0; i < 3; i++) n_init[13+i] = r_nonce[i];
    end

    cdk_round_core u_core (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_init (n_init),
        .o_state(core_x)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_valid) n_state = ST_LOAD;
            ST_LOAD:      n_state = ST_ROUND;
            ST_ROUND:     if (r_rnd == RW'(NROUNDS - 1)) n_state = ST_FEED;
            ST_FEED:      n_state = ST_OUT;
            ST_OUT:       if (i_ready && r_idx == 4'd15)
                              n_state = r_lastcall ? ST_RAT_ROUND : ST_IDLE;
            ST_RAT_ROUND: if (r_rnd == RW'(NROUNDS - 1)) n_state = ST_RAT_FEED;
            ST_RAT_FEED:  n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs and core control
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        ctrl = '0;
        case (r_state)
            ST_IDLE:      o_ready = 1'b1;
            ST_LOAD:      ctrl.load = 1'b1;
            ST_ROUND:     begin ctrl.step = 1'b1; ctrl.odd = r_rnd[0]; end
            ST_OUT:       begin
                o_valid = 1'b1;
                ctrl.load = i_ready && r_idx == 4'd15 && r_lastcall;
            end
            ST_RAT_ROUND: begin ctrl.step = 1'b1; ctrl.odd = r_rnd[0]; end
            default:      ;
        endcase
        // block loads in the cycle after the request, once any reseed has landed
    end

    assign o_keystream_word = r_out[r_idx];
    assign o_word_index = r_idx;
    assign o_last = r_idx == 4'd15;
    assign o_reseeded = r_resd;

    // reseed decision on request
    logic do_resd;
    assign do_resd = !r_inprog && (!r_seeded || r_prod >= {2'b0, r_interval});
    logic [6:0] take;
    assign take = (i_byte_count > 7'd64) ? 7'd64 : i_byte_count;
    logic [34:0] call_sum, prod_sum;
    assign call_sum = {1'b0, r_call} + 35'(take);
    assign prod_sum = {1'b0, r_prod} + {1'b0, r_call};

    // sequencer and drbg state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd <= '0; r_idx <= '0;
            for (int i = 0; i < 8; i++) r_key[i] <= '0;
            for (int i = 0; i < 3; i++) r_nonce[i] <= '0;
            r_ctr <= '0; r_seeded <= 1'b0; r_inprog <= 1'b0;
            r_prod <= '0; r_call <= '0; r_lastcall <= 1'b0; r_resd <= 1'b0;
            r_interval <= RESEED_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_interval <= i_cfg_wdata;
            if (r_state == ST_ROUND || r_state == ST_RAT_ROUND) r_rnd <= r_rnd + 1'b1;
            else r_rnd <= '0;
            if (accept) begin
                r_lastcall <= i_last_of_call;
                r_resd <= do_resd;
                r_call <= call_sum[34] ? SAT34 : call_sum[33:0];
                if (do_resd) begin
                    for (int k = 0; k < 4; k++) begin
                        logic [63:0] e;
                        e = (k == 0) ? i_entropy_key0 : (k == 1) ? i_entropy_key1 :
                            (k == 2) ? i_entropy_key2 : i_entropy_key3;
                        r_key[2*k]   <= r_seeded ? (r_key[2*k] ^ e[31:0]) : e[31:0];
                        r_key[2*k+1] <= r_seeded ? (r_key[2*k+1] ^ e[63:32]) : e[63:32];
                    end
                    r_ctr <= '0;
                    r_nonce[0] <= i_entropy_nonce[31:0];
                    r_nonce[1] <= i_entropy_nonce[63:32];
                    r_nonce[2] <= r_nonce[2] ^ i_entropy_extra[31:0];
                    r_seeded <= 1'b1;
                    r_prod <= '0;
                end
            end
            // counter advance after each block is loaded
            if (ctrl.load) begin
                r_ctr <= r_ctr + 1'b1;
                if (r_ctr == '1) r_nonce[0] <= r_nonce[0] + 1'b1;
            end
            if (r_state == ST_FEED) begin
                r_idx <= '0;
                for (int i = 0; i < 16; i++) r_out[i] <= core_x[i] + r_init[i];
                if (r_lastcall) begin
                    r_prod <= prod_sum[34] ? SAT34 : prod_sum[33:0];
                    r_call <= '0;
                    r_inprog <= 1'b0;
                end else begin
                    r_inprog <= 1'b1;
                end
            end
            if (r_state == ST_OUT && i_ready) r_idx <= r_idx + 1'b1;
            if (r_state == ST_RAT_FEED) begin
                for (int i = 0; i < 8; i++) r_key[i] <= core_x[i] + r_init[i];
            end
            if (ctrl.load) r_init <= n_init;
        end
    end

    `CDK_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !o_valid)
    `CDK_ASSERT_NXT(a_accept_rounds, i_clk, i_rst_n, accept, r_state == ST_LOAD)
    `CDK_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_valid && o_last, o_word_index == 4'd15)
endmodule
`default_nettype wire
